/* hdl/bpinc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box point counter package
// Shared widths, register indexes and payload types of the box point
// inside/nearby counter.
// ----------------------------------------------------------------------------
package bpinc_pkg;

  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 20;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // Compare width: twice a coordinate, or a size plus twice the margin, with sign.
  localparam int CMP_BITS   = COORD_BITS + 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int NUM_AXES   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEARBY_MARGIN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROUND_MODE   = 3'd4;

  localparam logic [SIZE_BITS-1:0] BOX_SIZE_RST = SIZE_BITS'(1000);
  localparam logic [SIZE_BITS-1:0] MARGIN_RST   = SIZE_BITS'(250);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         has_point;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]        inside_count;
    logic [COUNT_BITS-1:0]        nearby_count;
    logic signed [COORD_BITS-1:0] inside_min_x;
    logic signed [COORD_BITS-1:0] inside_min_y;
    logic signed [COORD_BITS-1:0] inside_min_z;
    logic signed [COORD_BITS-1:0] inside_max_x;
    logic signed [COORD_BITS-1:0] inside_max_y;
    logic signed [COORD_BITS-1:0] inside_max_z;
  } result_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] box_size_x;
    logic [SIZE_BITS-1:0] box_size_y;
    logic [SIZE_BITS-1:0] box_size_z;
    logic [SIZE_BITS-1:0] nearby_margin;
    logic                 ground_mode;
  } cfg_t;

  typedef struct packed {
    logic in_box;
    logic nearby;
  } class_t;

endpackage

/* hdl/box_point_inside_nearby_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box point inside/nearby counter
// Counts points of a cloud that fall inside a centred box or its margin shell
// and reports the bounding box of the inside points at the end of each cloud.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle except while the stall described
// below holds. Every transfer on the input channel goes into an input
// register; from there the point is classified, the running tallies and
// bounds are updated, and an item that closes the cloud loads the result
// register, from which the result is offered to the consumer. A point
// is inside when on every axis -size/2 <= p <= size/2, and nearby when it is
// not inside but lies within the box widened by the margin on every side;
// with ground mode set the widening below the box on z is dropped. Counts
// saturate at their all-ones value, and when no point was inside the bounds
// read back as the largest positive minimum and the most negative maximum.
// The input side only stalls when a closing item finds the result register
// still holding a result that has not been taken. Configuration is meant to be
// written between clouds, while no item is in flight; the write channel is
// always ready and takes effect on the next cycle.
// ----------------------------------------------------------------------------
module box_point_inside_nearby_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bpinc_pkg::point_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bpinc_pkg::result_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpinc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bpinc_pkg::SIZE_BITS-1:0]     cfg_wdata
);

  bpinc_pkg::cfg_t   cfg;
  bpinc_pkg::class_t cls;
  bpinc_pkg::point_t pt_r;
  logic              pt_valid_r, pt_valid_nxt;
  logic              slot_free;
  logic              fire;
  logic              in_xfer;

  // Configuration writes are accepted in every cycle.
  assign cfg_ready = 1'b1;

  bpinc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The registered item is processed unless it closes a cloud and the result
  // register is still occupied by a result the consumer has not taken.
  assign fire     = pt_valid_r && (!pt_r.last_point || slot_free);
  assign in_ready = !pt_valid_r || fire;
  assign in_xfer  = in_valid && in_ready;

  assign pt_valid_nxt = in_xfer || (pt_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r <= 1'b0;
    end else begin
      pt_valid_r <= pt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pt_r <= in_data;
    end
  end

  bpinc_classify u_classify (
    .pt  (pt_r),
    .cfg (cfg),
    .cls (cls)
  );

  bpinc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .pt        (pt_r),
    .cls       (cls),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .slot_free (slot_free)
  );

endmodule

/* hdl/bpinc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box point counter configuration registers
// Holds the box sizes, the nearby margin and the ground mode flag.
// ----------------------------------------------------------------------------
module bpinc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [bpinc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bpinc_pkg::SIZE_BITS-1:0]     cfg_wdata,
  output bpinc_pkg::cfg_t                     cfg
);

  bpinc_pkg::cfg_t cfg_r;
  bpinc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bpinc_pkg::REG_BOX_SIZE_X:    cfg_nxt.box_size_x    = cfg_wdata;
        bpinc_pkg::REG_BOX_SIZE_Y:    cfg_nxt.box_size_y    = cfg_wdata;
        bpinc_pkg::REG_BOX_SIZE_Z:    cfg_nxt.box_size_z    = cfg_wdata;
        bpinc_pkg::REG_NEARBY_MARGIN: cfg_nxt.nearby_margin = cfg_wdata;
        bpinc_pkg::REG_GROUND_MODE:   cfg_nxt.ground_mode   = cfg_wdata[0];
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_size_x    <= bpinc_pkg::BOX_SIZE_RST;
      cfg_r.box_size_y    <= bpinc_pkg::BOX_SIZE_RST;
      cfg_r.box_size_z    <= bpinc_pkg::BOX_SIZE_RST;
      cfg_r.nearby_margin <= bpinc_pkg::MARGIN_RST;
      cfg_r.ground_mode   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/bpinc_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box point counter classifier
// Decides whether a point lies inside the box or in the margin shell.
// ----------------------------------------------------------------------------
module bpinc_classify (
  input  bpinc_pkg::point_t pt,
  input  bpinc_pkg::cfg_t   cfg,
  output bpinc_pkg::class_t cls
);

  localparam int W = bpinc_pkg::CMP_BITS;

  logic signed [bpinc_pkg::COORD_BITS-1:0] p   [bpinc_pkg::NUM_AXES];
  logic [bpinc_pkg::SIZE_BITS-1:0]         sz  [bpinc_pkg::NUM_AXES];
  logic signed [W-1:0]                     tp  [bpinc_pkg::NUM_AXES];
  logic signed [W-1:0]                     s_w [bpinc_pkg::NUM_AXES];
  logic signed [W-1:0]                     n_hi[bpinc_pkg::NUM_AXES];
  logic signed [W-1:0]                     n_lo[bpinc_pkg::NUM_AXES];
  logic [bpinc_pkg::NUM_AXES-1:0]          in_ax;
  logic [bpinc_pkg::NUM_AXES-1:0]          nb_ax;
  logic signed [W-1:0]                     m2;

  assign p[0]  = pt.point_x;
  assign p[1]  = pt.point_y;
  assign p[2]  = pt.point_z;
  assign sz[0] = cfg.box_size_x;
  assign sz[1] = cfg.box_size_y;
  assign sz[2] = cfg.box_size_z;

  // Both sides are doubled so that odd sizes need no rounding.
  assign m2 = W'({cfg.nearby_margin, 1'b0});

  always_comb begin
    for (int i = 0; i < bpinc_pkg::NUM_AXES; i++) begin
      tp[i]   = W'(p[i]) <<< 1;
      s_w[i]  = W'(sz[i]);
      n_hi[i] = s_w[i] + m2;
      n_lo[i] = -n_hi[i];
      if (i == 2 && cfg.ground_mode) begin
        n_lo[i] = -s_w[i];
      end
      in_ax[i] = (tp[i] >= -s_w[i]) && (tp[i] <= s_w[i]);
      nb_ax[i] = (tp[i] >= n_lo[i]) && (tp[i] <= n_hi[i]);
    end
    cls.in_box = &in_ax;
    cls.nearby = &nb_ax;
  end

endmodule

/* hdl/bpinc_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box point counter accumulator
// Keeps the tallies and the inside bounding box and holds the result register.
// ----------------------------------------------------------------------------
module bpinc_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bpinc_pkg::point_t   pt,
  input  bpinc_pkg::class_t   cls,
  input  logic                out_ready,
  output logic                out_valid,
  output bpinc_pkg::result_t  out_data,
  output logic                slot_free
);

  logic [bpinc_pkg::COUNT_BITS-1:0]        in_tally_r, in_tally_nxt;
  logic [bpinc_pkg::COUNT_BITS-1:0]        nb_tally_r, nb_tally_nxt;
  logic signed [bpinc_pkg::COORD_BITS-1:0] lo_r [bpinc_pkg::NUM_AXES];
  logic signed [bpinc_pkg::COORD_BITS-1:0] hi_r [bpinc_pkg::NUM_AXES];
  logic signed [bpinc_pkg::COORD_BITS-1:0] lo_upd [bpinc_pkg::NUM_AXES];
  logic signed [bpinc_pkg::COORD_BITS-1:0] hi_upd [bpinc_pkg::NUM_AXES];
  logic signed [bpinc_pkg::COORD_BITS-1:0] p [bpinc_pkg::NUM_AXES];
  logic                                    take_in;
  logic                                    take_nb;
  logic                                    emit;
  logic                                    out_valid_r, out_valid_nxt;
  bpinc_pkg::result_t                      out_data_r, out_data_nxt;

  assign p[0] = pt.point_x;
  assign p[1] = pt.point_y;
  assign p[2] = pt.point_z;

  assign take_in = fire && pt.has_point && cls.in_box;
  assign take_nb = fire && pt.has_point && !cls.in_box && cls.nearby;
  assign emit    = fire && pt.last_point;

  always_comb begin
    in_tally_nxt = in_tally_r;
    nb_tally_nxt = nb_tally_r;
    if (take_in && in_tally_r != bpinc_pkg::COUNT_MAX) begin
      in_tally_nxt = in_tally_r + {{(bpinc_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end
    if (take_nb && nb_tally_r != bpinc_pkg::COUNT_MAX) begin
      nb_tally_nxt = nb_tally_r + {{(bpinc_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end
    for (int i = 0; i < bpinc_pkg::NUM_AXES; i++) begin
      lo_upd[i] = lo_r[i];
      hi_upd[i] = hi_r[i];
      if (take_in && p[i] < lo_r[i]) lo_upd[i] = p[i];
      if (take_in && p[i] > hi_r[i]) hi_upd[i] = p[i];
    end
  end

  // The result carries the totals including a point on the closing item.
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_data_nxt.inside_count = in_tally_nxt;
      out_data_nxt.nearby_count = nb_tally_nxt;
      out_data_nxt.inside_min_x = lo_upd[0];
      out_data_nxt.inside_min_y = lo_upd[1];
      out_data_nxt.inside_min_z = lo_upd[2];
      out_data_nxt.inside_max_x = hi_upd[0];
      out_data_nxt.inside_max_y = hi_upd[1];
      out_data_nxt.inside_max_z = hi_upd[2];
    end
  end

  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tally_r  <= '0;
      nb_tally_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bpinc_pkg::NUM_AXES; i++) begin
        lo_r[i] <= bpinc_pkg::COORD_MAX;
        hi_r[i] <= bpinc_pkg::COORD_MIN;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        in_tally_r <= '0;
        nb_tally_r <= '0;
        for (int i = 0; i < bpinc_pkg::NUM_AXES; i++) begin
          lo_r[i] <= bpinc_pkg::COORD_MAX;
          hi_r[i] <= bpinc_pkg::COORD_MIN;
        end
      end else begin
        in_tally_r <= in_tally_nxt;
        nb_tally_r <= nb_tally_nxt;
        for (int i = 0; i < bpinc_pkg::NUM_AXES; i++) begin
          lo_r[i] <= lo_upd[i];
          hi_r[i] <= hi_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
